// ===== hdl/rwmq_pkg.sv =====
package rwmq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int TAG_W     = 16;
  localparam int YEAR_W    = 12;
  localparam int CAP_W     = 4;
  localparam int CAP_MAX   = 15;
  localparam int SUM_W     = YEAR_W + CAP_W;
  localparam int STEP_W    = $clog2(SUM_W);
  localparam int STATUS_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_MEAN    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NODATA  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [YEAR_W-1:0] year;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/rwmq_ifs.sv =====
interface rwmq_in_if import rwmq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TAG_W-1:0]  item_tag;
  logic [YEAR_W-1:0] year;

  modport source (output valid, mode, item_tag, year, input ready);
  modport sink   (input valid, mode, item_tag, year, output ready);
endinterface

interface rwmq_out_if import rwmq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [YEAR_W-1:0]   mean_year;
  logic [TAG_W-1:0]    removed_tag;

  modport source (output valid, status, mean_year, removed_tag, input ready);
  modport sink   (input valid, status, mean_year, removed_tag, output ready);
endinterface

interface rwmq_cfg_if import rwmq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/ring_window_mean_queue.sv =====
// Remove, or insert with no nonzero year held: the op passes through the UPDATE and DONE states
// into the output register. Insert with a mean also passes through DIV, running the 16-step
// bit-serial divider plus a rounding step. A new item is taken only in IDLE, after the last result loads.
// Reset: queue empty, running sum and counts zero, capacity 5; entry store contents
// are undefined and need no clearing pass.
module ring_window_mean_queue import rwmq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  rwmq_cfg_if.sink     cfg_i,
  rwmq_in_if.sink      item_i,
  rwmq_out_if.source   result_o
);

  localparam int IDX_W   = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int MAX_CAP = DEPTH < CAP_MAX ? DEPTH : CAP_MAX;

  state_e              state_q, state_d;
  logic [CAP_W-1:0]    cap_q;
  logic [CAP_W-1:0]    head_q;
  logic [CAP_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CAP_W-1:0]    nz_q;
  logic                op_mode_q;
  logic [TAG_W-1:0]    op_tag_q;
  logic [YEAR_W-1:0]   op_year_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [YEAR_W-1:0]   res_mean_q;
  logic [TAG_W-1:0]    res_tag_q;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [YEAR_W-1:0]   out_mean_q;
  logic [TAG_W-1:0]    out_tag_q;

  logic [CAP_W-1:0]    cap_act;
  entry_t              hd;
  entry_t              new_entry;
  logic                is_insert;
  logic                pop;
  logic [CAP_W:0]      head_inc;
  logic [CAP_W-1:0]    head1;
  logic [CAP_W-1:0]    cnt1;
  logic [SUM_W-1:0]    sum1, sum2;
  logic [CAP_W-1:0]    nz1, nz2;
  logic [CAP_W:0]      slot_sum;
  logic [CAP_W-1:0]    slot;
  logic                need_div;

  logic                in_accept;
  logic                cfg_write;
  logic                out_free;
  logic                div_start;
  logic                store_we;
  logic                out_load;
  logic                div_done;
  logic [YEAR_W-1:0]   div_mean;

  always_comb begin
    cap_act = cap_q;
    if (cap_q == '0) begin
      cap_act = CAP_W'(1);
    end else if (int'(cap_q) > MAX_CAP) begin
      cap_act = CAP_W'(MAX_CAP);
    end
  end

  assign is_insert = (op_mode_q == MODE_INSERT);
  assign new_entry = '{tag: op_tag_q, year: op_year_q};

  always_comb begin
    pop      = is_insert ? (cnt_q >= cap_act) : (cnt_q != '0);
    head_inc = {1'b0, head_q} + 1'b1;
    head1    = head_q;
    cnt1     = cnt_q;
    sum1     = sum_q;
    nz1      = nz_q;
    if (pop) begin
      head1 = (head_inc >= {1'b0, cap_act}) ? '0 : head_inc[CAP_W-1:0];
      cnt1  = cnt_q - 1'b1;
      if (hd.year != '0) begin
        sum1 = sum_q - SUM_W'(hd.year);
        nz1  = nz_q - 1'b1;
      end
    end
    slot_sum = {1'b0, head1} + {1'b0, cnt1};
    slot     = (slot_sum >= {1'b0, cap_act}) ? CAP_W'(slot_sum - {1'b0, cap_act})
                                             : slot_sum[CAP_W-1:0];
    sum2     = sum1;
    nz2      = nz1;
    if (op_year_q != '0) begin
      sum2 = sum1 + SUM_W'(op_year_q);
      nz2  = nz1 + 1'b1;
    end
    need_div = is_insert && (nz2 != '0);
  end

  assign in_accept = item_i.valid && item_i.ready;
  assign cfg_write = cfg_i.valid && cfg_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_UPDATE;
      ST_UPDATE: state_d = need_div ? ST_DIV : ST_DONE;
      ST_DIV:    if (div_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_i.ready = 1'b0;
    div_start    = 1'b0;
    store_we     = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE:   item_i.ready = 1'b1;
      ST_UPDATE: begin
        div_start = need_div;
        store_we  = is_insert;
      end
      ST_DIV:    ;
      ST_DONE:   out_load = out_free;
      default:   ;
    endcase
  end

  assign cfg_i.ready = 1'b1;

  rwmq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (IDX_W'(slot)),
    .wdata_i (new_entry),
    .raddr_i (IDX_W'(head_q)),
    .rdata_o (hd)
  );

  rwmq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum2),
    .divisor_i  (nz2),
    .done_o     (div_done),
    .mean_o     (div_mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_RESET;
      head_q  <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      nz_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_write) begin
        cap_q  <= cfg_i.data;
        head_q <= '0;
        cnt_q  <= '0;
        sum_q  <= '0;
        nz_q   <= '0;
      end else if (state_q == ST_UPDATE) begin
        head_q <= head1;
        if (is_insert) begin
          cnt_q <= cnt1 + 1'b1;
          sum_q <= sum2;
          nz_q  <= nz2;
        end else begin
          cnt_q <= cnt1;
          sum_q <= sum1;
          nz_q  <= nz1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_mode_q <= item_i.mode;
      op_tag_q  <= item_i.item_tag;
      op_year_q <= item_i.year;
    end
    if (state_q == ST_UPDATE) begin
      res_mean_q <= '0;
      res_tag_q  <= '0;
      if (is_insert) begin
        res_status_q <= need_div ? STATUS_MEAN : STATUS_NODATA;
      end else if (cnt_q == '0) begin
        res_status_q <= STATUS_EMPTY;
      end else begin
        res_status_q <= STATUS_REMOVED;
        res_tag_q    <= hd.tag;
      end
    end else if (state_q == ST_DIV && div_done) begin
      res_mean_q <= div_mean;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_mean_q   <= res_mean_q;
      out_tag_q    <= res_tag_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.status      = out_status_q;
  assign result_o.mean_year   = out_mean_q;
  assign result_o.removed_tag = out_tag_q;

`ifndef ASSERT_OFF
  a_nz_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nz_q <= cnt_q) else $error("nonzero count exceeds entry count");

  a_cnt_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cap_act) else $error("entry count exceeds capacity");

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < cap_act) else $error("head index outside capacity");

  a_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nz_q == '0) |-> (sum_q == '0)) else $error("running sum without nonzero entries");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV)) else $error("divider finished outside divide state");
`endif

endmodule

// ===== hdl/rwmq_store.sv =====
module rwmq_store import rwmq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  entry_t                               wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output entry_t                               rdata_o
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/rwmq_div.sv =====
module rwmq_div import rwmq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [CAP_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [YEAR_W-1:0] mean_o
);

  logic              busy_q, busy_d;
  logic              fin_q, fin_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CAP_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CAP_W-1:0]  div_q, div_d;
  logic [YEAR_W-1:0] mean_q, mean_d;

  logic [CAP_W:0]    shifted;
  logic              ge;
  logic [CAP_W:0]    rem2;
  logic              inc;

  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    ge      = shifted >= {1'b0, div_q};
    rem2    = {rem_q, 1'b0};
    inc     = (rem2 > {1'b0, div_q}) || ((rem2 == {1'b0, div_q}) && quo_q[0]);

    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    mean_d = mean_q;

    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? CAP_W'(shifted - {1'b0, div_q}) : CAP_W'(shifted);
      quo_d  = {quo_q[SUM_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      mean_d = YEAR_W'(quo_q + SUM_W'(inc));
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    mean_q <= mean_d;
  end

  assign done_o = done_q;
  assign mean_o = mean_q;

endmodule
